>>> rtl/core/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types and constants for the LED pattern sequencer.
// ----------------------------------------------------------------------------
package lps_pkg;

	localparam int LED_W    = 8;
	localparam int TICKS_W  = 24;
	localparam int COUNT_W  = 26;
	localparam int SW_W     = 4;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	// Register byte addresses
	localparam logic [PADDR_W-1:0] ADDR_TICKS      = 3'd0;
	localparam logic [PADDR_W-1:0] ADDR_COUNT_DOWN = 3'd4;

	localparam logic [TICKS_W-1:0] TICKS_RESET = 24'd12500000;

	// Pattern modes
	localparam logic [1:0] MODE_BOUNCE  = 2'd0;
	localparam logic [1:0] MODE_COUNT   = 2'd1;
	localparam logic [1:0] MODE_DOUBLE  = 2'd2;
	localparam logic [1:0] MODE_FILL    = 2'd3;

	// Pattern constants
	localparam logic [LED_W-1:0] LED_LEFT  = 8'h80;
	localparam logic [LED_W-1:0] LED_RIGHT = 8'h01;
	localparam logic [LED_W-1:0] LED_FULL  = 8'hff;
	localparam logic [LED_W-1:0] LED_EMPTY = 8'h00;

	typedef struct packed {
		logic [TICKS_W-1:0] ticks_per_half_second;
		logic               count_down;
	} cfg_t;

	// Decoded tick held in the input register
	typedef struct packed {
		logic               idle;
		logic [1:0]         mode;
		logic [COUNT_W-1:0] period;
	} item_t;

	typedef struct packed {
		logic [LED_W-1:0] led_pattern;
		logic             stepped;
	} result_t;

endpackage

>>> rtl/core/led_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// led_pattern_sequencer
// LED chaser driven by timebase ticks, with APB configuration.
// ----------------------------------------------------------------------------
// Each input transaction is one timebase tick carrying the pattern and speed
// switches; each produces exactly one output transaction with the LED byte and
// a flag that is set when that tick advanced the pattern. A tick passes through
// an input register, where its mode and step period are decoded, and then the
// pattern update into the output register. One tick is taken every clock unless
// m_tready holds the output register full; the sequencer state updates once per
// tick. Configuration is to be written over APB only while no transaction is in
// flight; the user is bound by this, and the block itself does not enforce it.
module led_pattern_sequencer (
	input  logic                         clk,
	input  logic                         arst_n,
	// APB configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lps_pkg::PADDR_W-1:0]  paddr,
	input  logic [lps_pkg::PDATA_W-1:0]  pwdata,
	output logic [lps_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	// Tick input
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,  // [3:0] pattern_switches, [7:4] speed_switches
	// Result output
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [15:0]                  m_tdata   // [7:0] led_pattern, [8] stepped, rest zero
);

	lps_pkg::cfg_t    cfg;
	lps_pkg::item_t   item_s1;
	lps_pkg::result_t result;
	logic             valid_s1;
	logic             advance;
	logic             m_tvalid_q;
	lps_pkg::result_t result_q;

	assign advance  = valid_s1 && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, result_q.stepped, result_q.led_pattern};

	lps_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lps_input_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.cfg      (cfg),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	lps_step_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.item       (item_s1),
		.count_down (cfg.count_down),
		.result     (result)
	);

	// Output register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

endmodule

>>> rtl/core/lps_apb_regs.sv
// ----------------------------------------------------------------------------
// lps_apb_regs
// APB register file: tick count per half-second and count direction.
// ----------------------------------------------------------------------------
module lps_apb_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lps_pkg::PADDR_W-1:0]  paddr,
	input  logic [lps_pkg::PDATA_W-1:0]  pwdata,
	output logic [lps_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output lps_pkg::cfg_t                cfg
);

	lps_pkg::cfg_t cfg_q;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	// Write registers on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_half_second <= lps_pkg::TICKS_RESET;
			cfg_q.count_down            <= 1'b0;
		end else if (wr_en) begin
			case (paddr)
				lps_pkg::ADDR_TICKS: begin
					cfg_q.ticks_per_half_second <= pwdata[lps_pkg::TICKS_W-1:0];
				end
				lps_pkg::ADDR_COUNT_DOWN: begin
					cfg_q.count_down <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Read back
	always_comb begin
		case (paddr)
			lps_pkg::ADDR_TICKS: begin
				prdata = {{(lps_pkg::PDATA_W-lps_pkg::TICKS_W){1'b0}},
					cfg_q.ticks_per_half_second};
			end
			lps_pkg::ADDR_COUNT_DOWN: begin
				prdata = {{(lps_pkg::PDATA_W-1){1'b0}}, cfg_q.count_down};
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

>>> rtl/core/lps_input_stage.sv
// ----------------------------------------------------------------------------
// lps_input_stage
// Input register: decodes mode and step period of each accepted tick.
// ----------------------------------------------------------------------------
module lps_input_stage (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,
	input  lps_pkg::cfg_t                cfg,
	input  logic                         advance,
	output logic                         valid_s1,
	output lps_pkg::item_t               item_s1
);

	logic                         valid_q;
	lps_pkg::item_t               item_q;
	lps_pkg::item_t               item_d;
	logic [lps_pkg::SW_W-1:0]     pat;
	logic [lps_pkg::SW_W-1:0]     spd;
	logic [lps_pkg::COUNT_W-1:0]  t1;
	logic [lps_pkg::COUNT_W-1:0]  t2;

	assign pat = s_tdata[3:0];
	assign spd = s_tdata[7:4];
	assign t1  = {2'b00, cfg.ticks_per_half_second};
	assign t2  = {1'b0, cfg.ticks_per_half_second, 1'b0};

	assign s_tready = !valid_q || advance;
	assign valid_s1 = valid_q;
	assign item_s1  = item_q;

	// Decode mode (lowest switch wins) and period (lowest speed switch wins)
	always_comb begin
		item_d.idle = (pat == '0);
		if (pat[0]) begin
			item_d.mode = lps_pkg::MODE_BOUNCE;
		end else if (pat[1]) begin
			item_d.mode = lps_pkg::MODE_COUNT;
		end else if (pat[2]) begin
			item_d.mode = lps_pkg::MODE_DOUBLE;
		end else begin
			item_d.mode = lps_pkg::MODE_FILL;
		end
		if (spd[0] || spd == '0) begin
			item_d.period = t1;
		end else if (spd[1]) begin
			item_d.period = t2;
		end else if (spd[2]) begin
			item_d.period = t2 + t1;
		end else begin
			item_d.period = {cfg.ticks_per_half_second, 2'b00};
		end
	end

	// Hold the decoded tick until the core takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_q <= 1'b1;
		end else if (advance) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_q <= item_d;
		end
	end

endmodule

>>> rtl/core/lps_step_core.sv
// ----------------------------------------------------------------------------
// lps_step_core
// Sequencer state and the single-tick update of the LED pattern.
// ----------------------------------------------------------------------------
module lps_step_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  lps_pkg::item_t        item,
	input  logic                  count_down,
	output lps_pkg::result_t      result
);

	logic [lps_pkg::LED_W-1:0]    led_q;
	logic                         moving_left_q;
	logic                         entering_q;
	logic [lps_pkg::LED_W-1:0]    left_q;
	logic [lps_pkg::LED_W-1:0]    right_q;
	logic [lps_pkg::COUNT_W-1:0]  tick_q;

	logic [lps_pkg::LED_W-1:0]    led_e, led_d;
	logic [lps_pkg::LED_W-1:0]    left_e, left_d;
	logic [lps_pkg::LED_W-1:0]    right_e, right_d;
	logic                         dir_d;
	logic                         entering_d;
	logic [lps_pkg::COUNT_W-1:0]  tick_inc, tick_d;
	logic                         step;

	always_comb begin
		// Entry load
		led_e   = led_q;
		left_e  = left_q;
		right_e = right_q;
		if (entering_q) begin
			case (item.mode)
				lps_pkg::MODE_BOUNCE: led_e = lps_pkg::LED_LEFT;
				lps_pkg::MODE_COUNT:  led_e = count_down ? lps_pkg::LED_FULL
					: lps_pkg::LED_EMPTY;
				lps_pkg::MODE_DOUBLE: begin
					left_e  = lps_pkg::LED_RIGHT;
					right_e = lps_pkg::LED_LEFT;
				end
				default: led_e = lps_pkg::LED_EMPTY;
			endcase
		end
		tick_inc = (entering_q ? '0 : tick_q) + 26'd1;
		step     = !item.idle && (tick_inc >= item.period);

		// Pattern advance
		led_d   = led_e;
		left_d  = left_e;
		right_d = right_e;
		dir_d   = moving_left_q;
		if (step) begin
			case (item.mode)
				lps_pkg::MODE_BOUNCE: begin
					if (led_e == lps_pkg::LED_RIGHT) begin
						dir_d = 1'b1;
					end else if (led_e == lps_pkg::LED_LEFT) begin
						dir_d = 1'b0;
					end
					led_d = dir_d ? {led_e[6:0], 1'b0} : {1'b0, led_e[7:1]};
				end
				lps_pkg::MODE_COUNT: begin
					led_d = count_down ? led_e - 8'd1 : led_e + 8'd1;
				end
				lps_pkg::MODE_DOUBLE: begin
					led_d   = left_e | right_e;
					left_d  = {left_e[6:0], 1'b0};
					right_d = {1'b0, right_e[7:1]};
					if (left_d == '0 && right_d == '0) begin
						left_d  = lps_pkg::LED_RIGHT;
						right_d = lps_pkg::LED_LEFT;
					end
				end
				default: begin
					if (led_e == lps_pkg::LED_EMPTY) begin
						dir_d = 1'b0;
					end else if (led_e == lps_pkg::LED_FULL) begin
						dir_d = 1'b1;
					end
					led_d = dir_d ? {led_e[6:0], 1'b0} : {1'b1, led_e[7:1]};
				end
			endcase
		end

		// Idle clears the LEDs and re-arms entry
		entering_d = 1'b0;
		tick_d     = step ? '0 : tick_inc;
		if (item.idle) begin
			led_d      = lps_pkg::LED_EMPTY;
			left_d     = left_q;
			right_d    = right_q;
			dir_d      = moving_left_q;
			entering_d = 1'b1;
			tick_d     = '0;
		end

		result.led_pattern = led_d;
		result.stepped     = step;
	end

	// Commit the state for each processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_q         <= '0;
			moving_left_q <= 1'b0;
			entering_q    <= 1'b1;
			left_q        <= '0;
			right_q       <= '0;
			tick_q        <= '0;
		end else if (en) begin
			led_q         <= led_d;
			moving_left_q <= dir_d;
			entering_q    <= entering_d;
			left_q        <= left_d;
			right_q       <= right_d;
			tick_q        <= tick_d;
		end
	end

	a_idle_clears: assert property (@(posedge clk) disable iff (!arst_n)
		en && item.idle |=> led_q == '0 && entering_q && tick_q == '0)
		else $error("idle tick did not clear the sequencer");

	a_step_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		en && result.stepped |=> tick_q == '0)
		else $error("tick counter not restarted after a step");

	a_entry_once: assert property (@(posedge clk) disable iff (!arst_n)
		en && !item.idle |=> !entering_q)
		else $error("entry load not consumed by an active tick");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(led_q) && $stable(tick_q) && $stable(entering_q))
		else $error("sequencer state changed without a tick");

endmodule
